### design/lcg_pkg.sv
// Package for the line color gradient block.
// Holds shared widths, pipeline depths and the queue status type.
// No dependencies.
`default_nettype none

package lcg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CH_BITS        = 8;
  localparam int NUM_CH         = 3;
  localparam int COLOR_BITS     = CH_BITS * NUM_CH;
  localparam int QUEUE_DEPTH    = 4;

  // Multiply, add and magnitude stages, then one restoring step per quotient bit.
  // The quotient carries one bit above the channel to flag saturation.
  localparam int QUOT_BITS      = CH_BITS + 1;
  localparam int LANE_STAGES    = 3 + QUOT_BITS;

  // Front register, queue, lane stages and the output register.
  localparam int CAPACITY       = 1 + QUEUE_DEPTH + LANE_STAGES + 1;

  localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

### design/lcg_if.sv
// Channel interfaces of the line color gradient block: pixel words in, color words out.
// Depends on lcg_pkg.
`default_nettype none

interface lcg_pixel_if
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic signed [COORD_BITS-1:0] line_start_x;
  logic signed [COORD_BITS-1:0] line_start_y;
  logic [COLOR_BITS-1:0]        line_start_color;
  logic signed [COORD_BITS-1:0] line_end_x;
  logic signed [COORD_BITS-1:0] line_end_y;
  logic [COLOR_BITS-1:0]        line_end_color;
  logic signed [COORD_BITS:0]   extent_x;
  logic signed [COORD_BITS:0]   extent_y;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, line_start_x, line_start_y,
           line_start_color, line_end_x, line_end_y, line_end_color, extent_x, extent_y,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, line_start_x, line_start_y,
           line_start_color, line_end_x, line_end_y, line_end_color, extent_x, extent_y,
    output ready
  );
endinterface

interface lcg_color_if
  import lcg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] gradient_color;

  modport source (output valid, gradient_color, input ready);
  modport sink (input valid, gradient_color, output ready);
endinterface

`default_nettype wire

### design/line_color_gradient.sv
// Channel     | Dir | Handshake    | Word
// pixel       | in  | valid/ready  | pixel, line end points and colors, extents
// result      | out | valid/ready  | gradient_color
//
// One word is accepted per cycle unless a full queue holds the front register.
// Each per-channel divider makes one quotient bit per stage (nine steps).
// Reset (rst, synchronous) empties the front register, the queue and the pipeline.
// A stalled result holds the pipeline; the front keeps taking words until the queue fills.
// Depends on lcg_pkg, lcg_if, lcg_front, lcg_queue, lcg_lane, lcg_back.
`default_nettype none

module line_color_gradient
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lcg_pixel_if.sink   pixel,
  lcg_color_if.source result
);

  localparam int WORD_BITS = 2 * (COORD_BITS + 1) + 2 * COLOR_BITS + 1;

  logic                 wr_en;
  logic                 rd_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;
  q_status_t            q_status;

  lcg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .q_status (q_status)
  );

  lcg_queue #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_data  (rd_data),
    .q_status (q_status)
  );

  lcg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_data  (rd_data),
    .q_status (q_status),
    .rd_en    (rd_en),
    .result   (result)
  );

endmodule

`default_nettype wire

### design/lcg_front.sv
// Front end: accepts pixel words, picks the major axis, forms span and position,
// and flags words whose color is simply the end color. Depends on lcg_pkg, lcg_if.
`default_nettype none

module lcg_front
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lcg_pixel_if.sink             pixel,
  output logic                  wr_en,
  output logic [2*(COORD_BITS+1)+2*COLOR_BITS:0] wr_data,
  input  q_status_t             q_status
);

  localparam int DW        = COORD_BITS + 1;
  localparam int WORD_BITS = 2 * DW + 2 * COLOR_BITS + 1;

  logic                 f_valid;
  logic [WORD_BITS-1:0] f_word;

  logic                 x_major;
  logic signed [DW-1:0] span_x;
  logic signed [DW-1:0] span_y;
  logic signed [DW-1:0] pos_x;
  logic signed [DW-1:0] pos_y;
  logic signed [DW-1:0] span;
  logic signed [DW-1:0] pos;
  logic                 zero_span;
  logic                 use_end;

  always_comb begin
    x_major = pixel.extent_x > pixel.extent_y;
    span_x  = DW'(pixel.line_end_x) - DW'(pixel.line_start_x);
    span_y  = DW'(pixel.line_end_y) - DW'(pixel.line_start_y);
    pos_x   = DW'(pixel.pixel_x) - DW'(pixel.line_start_x);
    pos_y   = DW'(pixel.pixel_y) - DW'(pixel.line_start_y);
    if (x_major) begin
      span      = span_x;
      pos       = pos_x;
      zero_span = pixel.line_end_x == pixel.line_start_x;
    end else begin
      span      = span_y;
      pos       = pos_y;
      zero_span = pixel.line_end_y == pixel.line_start_y;
    end
    // A pixel already at the end color and a zero span both yield the end color.
    use_end = (pixel.pixel_color == pixel.line_end_color) || zero_span;
  end

  assign pixel.ready = !f_valid || !q_status.full;
  assign wr_en       = f_valid && !q_status.full;
  assign wr_data     = f_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (pixel.ready) begin
      f_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      f_word <= {use_end, span, pos, pixel.line_start_color, pixel.line_end_color};
    end
  end

endmodule

`default_nettype wire

### design/lcg_queue.sv
// Short queue between the front end and the color pipeline.
// Depends on lcg_pkg.
`default_nettype none

module lcg_queue
  import lcg_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output q_status_t        q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign rd_data        = entries[rd_ptr];
  assign q_status.empty = count == '0;
  assign q_status.full  = count == CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### design/lcg_lane.sv
// One color channel: forms span*s + pos*(e-s), then divides by span with a
// pipelined restoring divider, one quotient bit per stage. Depends on lcg_pkg.
`default_nettype none

module lcg_lane
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [CH_BITS-1:0]         s,
  input  logic [CH_BITS-1:0]         e,
  input  logic signed [COORD_BITS:0] span,
  input  logic signed [COORD_BITS:0] pos,
  output logic [CH_BITS-1:0]         ch
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + CH_BITS + 1;
  localparam int NW = PW + 1;
  localparam int QB = QUOT_BITS;

  logic signed [CH_BITS:0] s_sx;
  logic signed [CH_BITS:0] diff;

  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [DW-1:0] span_1;
  logic signed [NW-1:0] num;
  logic signed [DW-1:0] span_2;

  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] den [QB+1];
  logic [QB-1:0] quot [QB+1];
  logic          zro [QB+1];

  logic [NW-1:0] trial [QB];
  logic          ge [QB];

  always_comb begin
    s_sx = $signed({1'b0, s});
    diff = $signed({1'b0, e}) - $signed({1'b0, s});
  end

  // Each step compares the remainder against the divisor shifted to the bit at hand.
  always_comb begin
    for (int j = 0; j < QB; j++) begin
      trial[j] = NW'(den[j]) << (QB - 1 - j);
      ge[j]    = rem[j] >= trial[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a  <= span * s_sx;
      prod_b  <= pos * diff;
      span_1  <= span;
      num     <= NW'(prod_a) + NW'(prod_b);
      span_2  <= span_1;
      // Opposite signs give a quotient that truncates to zero or below, which clamps to zero.
      rem[0]  <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
      den[0]  <= span_2[DW-1] ? $unsigned(-span_2) : $unsigned(span_2);
      zro[0]  <= num[NW-1] ^ span_2[DW-1];
      quot[0] <= '0;
      for (int j = 0; j < QB; j++) begin
        rem[j+1]  <= ge[j] ? rem[j] - trial[j] : rem[j];
        den[j+1]  <= den[j];
        zro[j+1]  <= zro[j];
        quot[j+1] <= quot[j] | (QB'(ge[j]) << (QB - 1 - j));
      end
    end
  end

  // The top quotient bit is set for any quotient of 256 or more.
  assign ch = zro[QB] ? '0 : (quot[QB][CH_BITS] ? CH_MAX : quot[QB][CH_BITS-1:0]);

endmodule

`default_nettype wire

### design/lcg_back.sv
// Back end: pops classified words, runs the three channel lanes in lockstep and
// holds the finished color in the output register. Depends on lcg_pkg, lcg_if, lcg_lane.
`default_nettype none

module lcg_back
  import lcg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2*(COORD_BITS+1)+2*COLOR_BITS:0] rd_data,
  input  q_status_t             q_status,
  output logic                  rd_en,
  lcg_color_if.source           result
);

  localparam int DW = COORD_BITS + 1;

  logic                  adv;
  logic                  w_use_end;
  logic signed [DW-1:0]  w_span;
  logic signed [DW-1:0]  w_pos;
  logic [COLOR_BITS-1:0] w_start_color;
  logic [COLOR_BITS-1:0] w_end_color;
  logic [COLOR_BITS-1:0] blended;

  logic                  vld [LANE_STAGES];
  logic                  use_end_p [LANE_STAGES];
  logic [COLOR_BITS-1:0] end_color_p [LANE_STAGES];

  assign {w_use_end, w_span, w_pos, w_start_color, w_end_color} = rd_data;

  // The whole pipeline moves whenever the output register is free or being emptied.
  assign adv   = !result.valid || result.ready;
  assign rd_en = adv && !q_status.empty;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    lcg_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .s    (w_start_color[c*CH_BITS +: CH_BITS]),
      .e    (w_end_color[c*CH_BITS +: CH_BITS]),
      .span (w_span),
      .pos  (w_pos),
      .ch   (blended[c*CH_BITS +: CH_BITS])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANE_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
      result.valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= !q_status.empty;
      for (int k = 1; k < LANE_STAGES; k++) begin
        vld[k] <= vld[k-1];
      end
      result.valid <= vld[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      use_end_p[0]   <= w_use_end;
      end_color_p[0] <= w_end_color;
      for (int k = 1; k < LANE_STAGES; k++) begin
        use_end_p[k]   <= use_end_p[k-1];
        end_color_p[k] <= end_color_p[k-1];
      end
      result.gradient_color <= use_end_p[LANE_STAGES-1] ? end_color_p[LANE_STAGES-1]
                                                         : blended;
    end
  end

endmodule

`default_nettype wire

### design/lcg_checker.sv
// Port-level checks for the line color gradient block, bound to the top level.
// Depends on lcg_pkg and line_color_gradient.
`default_nettype none

module lcg_port_checks
  import lcg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COLOR_BITS-1:0] out_color
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1) + 1;

  logic [CNT_BITS-1:0] outstanding;
  logic                in_acc;
  logic                out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_color))
    else $error("result word changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result word shown with no pixel word outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_BITS'(CAPACITY))
    else $error("more words in flight than the block can hold");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    outstanding == '0 |-> in_ready)
    else $error("pixel channel not ready while the block is empty");

endmodule

bind line_color_gradient lcg_port_checks u_lcg_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_color (result.gradient_color)
);

`default_nettype wire
